/* hdl/wsfd_pkg.sv */
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types, codes and sizes of the WebSocket frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // Input command codes.
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_NEED_MORE = 2'd0;
  localparam logic [1:0] ST_COMPLETE  = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  // Error kinds.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_MASKED     = 3'd1;
  localparam logic [2:0] ERR_RESERVED   = 3'd2;
  localparam logic [2:0] ERR_FRAGMENTED = 3'd3;
  localparam logic [2:0] ERR_BAD_OPCODE = 3'd4;
  localparam logic [2:0] ERR_CTRL_LONG  = 3'd5;
  localparam logic [2:0] ERR_TOO_LARGE  = 3'd6;

  // Frame opcodes.
  localparam logic [3:0] OP_CONTINUATION = 4'h0;
  localparam logic [3:0] OP_TEXT         = 4'h1;
  localparam logic [3:0] OP_BINARY       = 4'h2;
  localparam logic [3:0] OP_CLOSE        = 4'h8;
  localparam logic [3:0] OP_PING         = 4'h9;
  localparam logic [3:0] OP_PONG         = 4'hA;

  // Header bit fields.
  localparam logic [7:0] HDR_RSV_MASK = 8'h70;
  localparam logic [7:0] HDR_OP_MASK  = 8'h0F;
  localparam logic [7:0] HDR_TOP_BIT  = 8'h80;
  localparam logic [7:0] HDR_LEN_MASK = 8'h7F;
  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;

  // Configuration register indexes and reset values.
  localparam logic CFG_IDX_CAPACITY = 1'b0;
  localparam logic CFG_IDX_CTRL_LEN = 1'b1;
  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
  localparam logic [6:0]  CTRL_LEN_RESET = 7'd125;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Decoder phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_EXTLEN  = 3'b010,
    PH_PAYLOAD = 3'b100
  } wsfd_phase_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic       command;
    logic [7:0] data;
    logic [3:0] op;
    logic       rsv_set;
    logic       fin_clear;
    logic       op_zero;
    logic       op_unknown;
    logic       op_control;
    logic       mask_set;
    logic [6:0] len7;
    logic       len_ext16;
    logic       len_ext64;
  } wsfd_class_t;

  // Configuration as seen by the back.
  typedef struct packed {
    logic [15:0] buffer_capacity;
    logic [6:0]  max_control_len;
  } wsfd_cfg_t;

  // One result item.
  typedef struct packed {
    logic        byte_taken;
    logic [1:0]  status;
    logic [2:0]  error_kind;
    logic [3:0]  frame_opcode;
    logic [15:0] frame_length;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
  } wsfd_result_t;

endpackage

/* hdl/wsfd_in_if.sv */
// ----------------------------------------------------------------------------
// wsfd_in_if
// Input channel of the decoder: one command and one stream byte per beat.
// ----------------------------------------------------------------------------
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

/* hdl/wsfd_out_if.sv */
// ----------------------------------------------------------------------------
// wsfd_out_if
// Result channel of the decoder: one result per beat.
// ----------------------------------------------------------------------------
interface wsfd_out_if;
  logic        valid;
  logic        ready;
  logic        byte_taken;
  logic [1:0]  status;
  logic [2:0]  error_kind;
  logic [3:0]  frame_opcode;
  logic [15:0] frame_length;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_offset;

  modport source (output valid, byte_taken, status, error_kind, frame_opcode,
                  frame_length, payload_valid, payload_byte, payload_offset,
                  input ready);
  modport sink   (input valid, byte_taken, status, error_kind, frame_opcode,
                  frame_length, payload_valid, payload_byte, payload_offset,
                  output ready);
endinterface

/* hdl/wsfd_front.sv */
// ----------------------------------------------------------------------------
// wsfd_front
// Accepts input beats and classifies each byte as a header candidate.
// ----------------------------------------------------------------------------
module wsfd_front (
  input  logic                 clk,
  input  logic                 rst,
  wsfd_in_if.sink              stream,
  output logic                 push_valid,
  input  logic                 push_ready,
  output wsfd_pkg::wsfd_class_t push_item
);
  import wsfd_pkg::*;

  logic        full;
  wsfd_class_t item;
  wsfd_class_t cls;
  logic [3:0]  op;

  assign stream.ready = !full || push_ready;
  assign push_valid   = full;
  assign push_item    = item;
  assign op           = stream.data_byte[3:0] & HDR_OP_MASK[3:0];

  // The byte is judged both as a first and as a second header byte; the back
  // picks whichever view fits its phase.
  always_comb begin
    cls            = '0;
    cls.command    = stream.command;
    cls.data       = stream.data_byte;
    cls.op         = op;
    cls.rsv_set    = (stream.data_byte & HDR_RSV_MASK) != 8'h00;
    cls.fin_clear  = (stream.data_byte & HDR_TOP_BIT) == 8'h00;
    cls.op_control = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    cls.op_zero    = op == OP_CONTINUATION;
    cls.op_unknown = !((op == OP_TEXT) || (op == OP_BINARY) || cls.op_control
                       || cls.op_zero);
    cls.mask_set   = (stream.data_byte & HDR_TOP_BIT) != 8'h00;
    cls.len7       = stream.data_byte[6:0] & HDR_LEN_MASK[6:0];
    cls.len_ext16  = cls.len7 == LEN7_EXT16;
    cls.len_ext64  = cls.len7 == LEN7_EXT64;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      full <= 1'b1;
    end else if (push_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      item <= cls;
    end
  end

endmodule

/* hdl/wsfd_queue.sv */
// ----------------------------------------------------------------------------
// wsfd_queue
// Short first-in first-out queue of classified bytes.
// ----------------------------------------------------------------------------
module wsfd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  wsfd_pkg::wsfd_class_t push_item,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output wsfd_pkg::wsfd_class_t pop_item
);
  import wsfd_pkg::*;

  wsfd_class_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* hdl/wsfd_back.sv */
// ----------------------------------------------------------------------------
// wsfd_back
// Frame state machine: walks header, extended length and payload, and holds
// the result register of the output channel.
// ----------------------------------------------------------------------------
module wsfd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  wsfd_pkg::wsfd_cfg_t   cfg,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  wsfd_pkg::wsfd_class_t pop_item,
  wsfd_out_if.source            result
);
  import wsfd_pkg::*;

  wsfd_phase_t  phase, phase_next, eff_phase;
  logic         header_count, header_count_next, eff_header_count;
  logic         ext_count, ext_count_next, eff_ext_count;
  logic [7:0]   ext_high_byte, ext_high_byte_next;
  logic [15:0]  expected_length, expected_length_next, eff_expected_length;
  logic [15:0]  fill_count, fill_count_next, eff_fill_count, fill_inc;
  logic [3:0]   current_opcode, current_opcode_next;
  logic         frame_done, frame_done_next;
  logic [2:0]   sticky_error, sticky_error_next;
  // Flags of the first header byte, kept for the checks on the second.
  logic [3:0]   hdr_op, hdr_op_next;
  logic         hdr_rsv, hdr_rsv_next;
  logic         hdr_fin_clear, hdr_fin_clear_next;
  logic         hdr_op_zero, hdr_op_zero_next;
  logic         hdr_op_unknown, hdr_op_unknown_next;
  logic         hdr_control, hdr_control_next;

  logic         out_full;
  wsfd_result_t out_reg;
  wsfd_result_t res;
  logic         pop;
  logic [1:0]   st;
  logic         do_accept;
  logic [15:0]  acc_len;
  logic         acc_over;

  assign pop_ready = !out_full || result.ready;
  assign pop       = pop_valid && pop_ready;

  // A completed frame leaves its counters until the next data byte arrives.
  assign eff_phase           = frame_done ? PH_HEADER : phase;
  assign eff_header_count    = frame_done ? 1'b0 : header_count;
  assign eff_ext_count       = frame_done ? 1'b0 : ext_count;
  assign eff_expected_length = frame_done ? 16'd0 : expected_length;
  assign eff_fill_count      = frame_done ? 16'd0 : fill_count;
  assign fill_inc            = eff_fill_count + 16'd1;

  assign acc_len  = (eff_phase == PH_EXTLEN) ? {ext_high_byte, pop_item.data}
                                             : {9'd0, pop_item.len7};
  assign acc_over = acc_len > cfg.buffer_capacity;

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    ext_count_next       = ext_count;
    ext_high_byte_next   = ext_high_byte;
    expected_length_next = expected_length;
    fill_count_next      = fill_count;
    current_opcode_next  = current_opcode;
    frame_done_next      = frame_done;
    sticky_error_next    = sticky_error;
    hdr_op_next          = hdr_op;
    hdr_rsv_next         = hdr_rsv;
    hdr_fin_clear_next   = hdr_fin_clear;
    hdr_op_zero_next     = hdr_op_zero;
    hdr_op_unknown_next  = hdr_op_unknown;
    hdr_control_next     = hdr_control;
    res                  = '0;
    st                   = ST_NEED_MORE;
    do_accept            = 1'b0;

    if (pop_item.command == CMD_RESTART) begin
      phase_next           = PH_HEADER;
      header_count_next    = 1'b0;
      ext_count_next       = 1'b0;
      ext_high_byte_next   = 8'd0;
      expected_length_next = 16'd0;
      fill_count_next      = 16'd0;
      current_opcode_next  = OP_CONTINUATION;
      frame_done_next      = 1'b0;
      sticky_error_next    = ERR_NONE;
      hdr_op_next          = OP_CONTINUATION;
      hdr_rsv_next         = 1'b0;
      hdr_fin_clear_next   = 1'b0;
      hdr_op_zero_next     = 1'b0;
      hdr_op_unknown_next  = 1'b0;
      hdr_control_next     = 1'b0;
    end else if (sticky_error != ERR_NONE) begin
      st = ST_ERROR;
    end else begin
      phase_next           = eff_phase;
      header_count_next    = eff_header_count;
      ext_count_next       = eff_ext_count;
      expected_length_next = eff_expected_length;
      fill_count_next      = eff_fill_count;
      frame_done_next      = 1'b0;
      res.byte_taken       = 1'b1;
      unique case (eff_phase)
        PH_EXTLEN: begin
          if (!eff_ext_count) begin
            ext_high_byte_next = pop_item.data;
            ext_count_next     = 1'b1;
          end else begin
            ext_count_next = 1'b0;
            do_accept      = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res.payload_valid  = 1'b1;
          res.payload_byte   = pop_item.data;
          res.payload_offset = eff_fill_count;
          fill_count_next    = fill_inc;
          if (fill_inc == eff_expected_length) begin
            frame_done_next = 1'b1;
            st              = ST_COMPLETE;
          end
        end
        default: begin
          if (!eff_header_count) begin
            hdr_op_next         = pop_item.op;
            hdr_rsv_next        = pop_item.rsv_set;
            hdr_fin_clear_next  = pop_item.fin_clear;
            hdr_op_zero_next    = pop_item.op_zero;
            hdr_op_unknown_next = pop_item.op_unknown;
            hdr_control_next    = pop_item.op_control;
            header_count_next   = 1'b1;
          end else begin
            header_count_next = 1'b0;
            if (hdr_rsv) begin
              sticky_error_next = ERR_RESERVED;
              st                = ST_ERROR;
            end else if (hdr_op_zero) begin
              sticky_error_next = ERR_FRAGMENTED;
              st                = ST_ERROR;
            end else if (hdr_op_unknown) begin
              sticky_error_next = ERR_BAD_OPCODE;
              st                = ST_ERROR;
            end else if (hdr_fin_clear) begin
              sticky_error_next = ERR_FRAGMENTED;
              st                = ST_ERROR;
            end else if (pop_item.mask_set) begin
              sticky_error_next = ERR_MASKED;
              st                = ST_ERROR;
            end else begin
              current_opcode_next = hdr_op;
              if (hdr_control && (pop_item.len7 > cfg.max_control_len)) begin
                sticky_error_next = ERR_CTRL_LONG;
                st                = ST_ERROR;
              end else if (pop_item.len_ext64) begin
                sticky_error_next = ERR_TOO_LARGE;
                st                = ST_ERROR;
              end else if (pop_item.len_ext16) begin
                phase_next = PH_EXTLEN;
              end else begin
                do_accept = 1'b1;
              end
            end
          end
        end
      endcase

      // Final length of a header: check against capacity, then end an empty frame or start payload.
      if (do_accept) begin
        expected_length_next = acc_len;
        if (acc_over) begin
          sticky_error_next = ERR_TOO_LARGE;
          st                = ST_ERROR;
        end else if (acc_len == 16'd0) begin
          frame_done_next = 1'b1;
          st              = ST_COMPLETE;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end

    if (pop_item.command != CMD_RESTART) begin
      res.status       = st;
      res.frame_opcode = current_opcode_next;
      res.error_kind   = (st == ST_ERROR) ? sticky_error_next : ERR_NONE;
      res.frame_length = (st == ST_COMPLETE) ? expected_length_next : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= 1'b0;
      ext_count       <= 1'b0;
      ext_high_byte   <= 8'd0;
      expected_length <= 16'd0;
      fill_count      <= 16'd0;
      current_opcode  <= OP_CONTINUATION;
      frame_done      <= 1'b0;
      sticky_error    <= ERR_NONE;
      hdr_op          <= OP_CONTINUATION;
      hdr_rsv         <= 1'b0;
      hdr_fin_clear   <= 1'b0;
      hdr_op_zero     <= 1'b0;
      hdr_op_unknown  <= 1'b0;
      hdr_control     <= 1'b0;
      out_full        <= 1'b0;
    end else begin
      if (pop) begin
        phase           <= phase_next;
        header_count    <= header_count_next;
        ext_count       <= ext_count_next;
        ext_high_byte   <= ext_high_byte_next;
        expected_length <= expected_length_next;
        fill_count      <= fill_count_next;
        current_opcode  <= current_opcode_next;
        frame_done      <= frame_done_next;
        sticky_error    <= sticky_error_next;
        hdr_op          <= hdr_op_next;
        hdr_rsv         <= hdr_rsv_next;
        hdr_fin_clear   <= hdr_fin_clear_next;
        hdr_op_zero     <= hdr_op_zero_next;
        hdr_op_unknown  <= hdr_op_unknown_next;
        hdr_control     <= hdr_control_next;
        out_full        <= 1'b1;
      end else if (result.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= res;
    end
  end

  assign result.valid          = out_full;
  assign result.byte_taken     = out_reg.byte_taken;
  assign result.status         = out_reg.status;
  assign result.error_kind     = out_reg.error_kind;
  assign result.frame_opcode   = out_reg.frame_opcode;
  assign result.frame_length   = out_reg.frame_length;
  assign result.payload_valid  = out_reg.payload_valid;
  assign result.payload_byte   = out_reg.payload_byte;
  assign result.payload_offset = out_reg.payload_offset;

endmodule

/* hdl/websocket_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// websocket_frame_decoder_top
// Byte-stream decoder for unmasked server-to-client WebSocket frames.
// ----------------------------------------------------------------------------
// Each input beat carries one received byte (or a restart command) and yields
// exactly one result beat. The decoder parses the two header bytes and an
// optional 16-bit extended length, then passes every payload byte straight
// out with its offset in the frame; the result that carries the last payload
// byte (or the last length byte, for an empty frame) reports the frame as
// complete with its opcode and length. Header errors are checked in a fixed
// order and stick: until a restart beat arrives, every data beat is answered
// with byte_taken low and the held error kind. The block sustains one byte
// per clock while neither side stalls; each beat passes through the input
// register, the two-entry queue and the result register, and the turn of the
// frame state machine in the back end is what sets the rate.
// Either side may stall independently: the queue and the result register
// absorb back pressure. The two configuration registers, buffer capacity at
// byte address 0 and control-frame length limit at byte address 4, sit on an
// APB-style port and must only be written while no beat is in flight.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_top (
  input  logic        clk,
  input  logic        rst,
  wsfd_in_if.sink     stream,
  wsfd_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wsfd_pkg::*;

  wsfd_cfg_t   cfg;
  logic        cfg_write;
  logic        q_push_valid;
  logic        q_push_ready;
  wsfd_class_t q_push_item;
  logic        q_pop_valid;
  logic        q_pop_ready;
  wsfd_class_t q_pop_item;

  // Configuration port. Writes complete in the access phase; pready is tied
  // high, so there are no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_capacity <= CAPACITY_RESET;
      cfg.max_control_len <= CTRL_LEN_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        CFG_IDX_CAPACITY: cfg.buffer_capacity <= pwdata[15:0];
        CFG_IDX_CTRL_LEN: cfg.max_control_len <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_CAPACITY: prdata = {16'd0, cfg.buffer_capacity};
      CFG_IDX_CTRL_LEN: prdata = {25'd0, cfg.max_control_len};
      default:          prdata = 32'd0;
    endcase
  end

  // Front end: takes each beat and classifies the byte.
  wsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item)
  );

  // Queue that lets the front keep accepting while the result side stalls.
  wsfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  // Back end: frame state machine and result register.
  wsfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_item  (q_pop_item),
    .result    (result)
  );

endmodule

/* test/websocket_frame_decoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder_top_tb
// Self-checking bench for the byte-stream WebSocket frame decoder.
// ----------------------------------------------------------------------------
// Bytes go in on the stream channel and one result beat per input beat comes
// back. The bench keeps a cycle-free model of the decoder, so every accepted
// input beat immediately yields the result it must cause, and the monitor
// checks the outgoing beats against those predictions in order. A short
// directed table opens the run, then random traffic under several register
// settings, and finally frames at the capacity and length-field boundaries.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_top_tb;
  import wsfd_pkg::*;

  // Cycles the receiver refuses beats when the bench squeezes the block.
  localparam int LONG_HOLD = 80;
  // How many mismatches are printed in detail.
  localparam int SHOW_LIMIT = 10;

  // Decoder position inside a frame, as the bench tracks it.
  typedef enum logic [1:0] {
    SEEK_HEADER  = 2'd0,
    SEEK_EXTLEN  = 2'd1,
    SEEK_PAYLOAD = 2'd2
  } seek_t;

  // One input beat waiting to be sent.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } in_beat_t;

  // One row of the directed table. When fixed is set, the result is typed
  // into the table; otherwise the model supplies it.
  typedef struct packed {
    logic         cmd;
    logic [7:0]   data;
    logic         fixed;
    wsfd_result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wsfd_in_if  stream_if ();
  wsfd_out_if result_if ();

  websocket_frame_decoder_top dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Results the decoder still owes, oldest first.
  wsfd_result_t due_results[$];
  in_beat_t     tx_beats[$];
  dir_row_t     dir_table[$];

  int fail_count;
  int burst_left;
  // The main flow raises hold_asked; the receiver answers with hold_served.
  // While they differ the sender offers beats back to back.
  int hold_asked;
  int hold_served;

  // Shadow decoder state and registers.
  seek_t       ph;
  logic        hdr_cnt;
  logic [7:0]  hdr0;
  logic        ext_cnt;
  logic [7:0]  ext_hi;
  logic [15:0] exp_len;
  logic [15:0] fill;
  logic [3:0]  cur_op;
  logic        done;
  logic [2:0]  err;
  logic [15:0] cap_q;
  logic [6:0]  ctrl_q;

  // --------------------------------------------------------------------------
  // Clock and watchdog.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A correct run finishes well before this point.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the decoder.
  // --------------------------------------------------------------------------

  // Restart clears everything except the two registers.
  function automatic void clear_decoder();
    ph      = SEEK_HEADER;
    hdr_cnt = 1'b0;
    hdr0    = 8'h00;
    ext_cnt = 1'b0;
    ext_hi  = 8'h00;
    exp_len = 16'd0;
    fill    = 16'd0;
    cur_op  = OP_CONTINUATION;
    done    = 1'b0;
    err     = ERR_NONE;
  endfunction

  // A length is final: it may be too large, empty, or open the payload.
  function automatic logic [1:0] take_length(input logic [15:0] len);
    exp_len = len;
    if (len > cap_q) begin
      err = ERR_TOO_LARGE;
      return ST_ERROR;
    end
    if (len == 16'd0) begin
      done = 1'b1;
      return ST_COMPLETE;
    end
    ph = SEEK_PAYLOAD;
    return ST_NEED_MORE;
  endfunction

  // Header checks, in their fixed order, once the second byte is in.
  function automatic logic [1:0] check_header(input logic [7:0] b);
    logic [3:0] op;
    logic [6:0] len7;
    logic       ctl;
    op      = hdr0[3:0];
    len7    = b[6:0];
    ctl     = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    hdr_cnt = 1'b0;
    if ((hdr0 & HDR_RSV_MASK) != 8'h00) begin
      err = ERR_RESERVED;
    end else if (op == OP_CONTINUATION) begin
      err = ERR_FRAGMENTED;
    end else if (op != OP_TEXT && op != OP_BINARY && !ctl) begin
      err = ERR_BAD_OPCODE;
    end else if ((hdr0 & HDR_TOP_BIT) == 8'h00) begin
      err = ERR_FRAGMENTED;
    end else if ((b & HDR_TOP_BIT) != 8'h00) begin
      err = ERR_MASKED;
    end else begin
      cur_op = op;
      if (ctl && len7 > ctrl_q) begin
        err = ERR_CTRL_LONG;
      end else if (len7 == LEN7_EXT64) begin
        err = ERR_TOO_LARGE;
      end else if (len7 == LEN7_EXT16) begin
        ph = SEEK_EXTLEN;
      end else begin
        return take_length({9'd0, len7});
      end
    end
    return (err != ERR_NONE) ? ST_ERROR : ST_NEED_MORE;
  endfunction

  // The result one accepted input beat must produce.
  function automatic wsfd_result_t decode_beat(input logic cmd, input logic [7:0] b);
    wsfd_result_t r;
    logic [1:0]   st;
    r  = '0;
    st = ST_NEED_MORE;
    if (cmd == CMD_RESTART) begin
      clear_decoder();
      return r;
    end
    if (err != ERR_NONE) begin
      st = ST_ERROR;
    end else begin
      if (done) begin
        done    = 1'b0;
        ph      = SEEK_HEADER;
        hdr_cnt = 1'b0;
        ext_cnt = 1'b0;
        exp_len = 16'd0;
        fill    = 16'd0;
      end
      r.byte_taken = 1'b1;
      case (ph)
        SEEK_EXTLEN: begin
          if (!ext_cnt) begin
            ext_hi  = b;
            ext_cnt = 1'b1;
          end else begin
            ext_cnt = 1'b0;
            st      = take_length({ext_hi, b});
          end
        end
        SEEK_PAYLOAD: begin
          r.payload_valid  = 1'b1;
          r.payload_byte   = b;
          r.payload_offset = fill;
          fill = fill + 16'd1;
          if (fill == exp_len) begin
            done = 1'b1;
            st   = ST_COMPLETE;
          end
        end
        default: begin
          if (!hdr_cnt) begin
            hdr0    = b;
            hdr_cnt = 1'b1;
          end else begin
            st = check_header(b);
          end
        end
      endcase
    end
    r.status       = st;
    r.error_kind   = (st == ST_ERROR) ? err : ERR_NONE;
    r.frame_opcode = cur_op;
    r.frame_length = (st == ST_COMPLETE) ? exp_len : 16'd0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation.
  // --------------------------------------------------------------------------
  function automatic void put_beat(input logic cmd, input logic [7:0] data);
    in_beat_t t;
    t.cmd  = cmd;
    t.data = data;
    tx_beats.push_back(t);
  endfunction

  // Random byte that leans toward the all-zero and all-one corners.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [3:0] rand_good_op();
    case ($urandom_range(0, 4))
      0:       return OP_TEXT;
      1:       return OP_BINARY;
      2:       return OP_CLOSE;
      3:       return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  // A complete, well-formed frame: header, optional 16-bit length, payload.
  function automatic void build_frame(input logic [3:0] op, input int len, input bit ext);
    logic [15:0] n;
    n = 16'(len);
    put_beat(CMD_DATA, HDR_TOP_BIT | {4'h0, op});
    if (ext) begin
      put_beat(CMD_DATA, {1'b0, LEN7_EXT16});
      put_beat(CMD_DATA, n[15:8]);
      put_beat(CMD_DATA, n[7:0]);
    end else begin
      put_beat(CMD_DATA, {1'b0, n[6:0]});
    end
    repeat (len) put_beat(CMD_DATA, rand_byte());
  endfunction

  // A frame that passes every check under the current registers. Now and
  // then it is cut short by a restart.
  function automatic void add_good_frame();
    logic [3:0] op;
    int         lim;
    int         len;
    int         pick;
    int         start;
    bit         ext;
    op    = rand_good_op();
    lim   = (cap_q < 140) ? int'(cap_q) : 140;
    ext   = 1'b0;
    start = tx_beats.size();
    if (op[3]) begin
      // Close, ping and pong; with a raised limit they may use 16-bit length.
      if (ctrl_q >= LEN7_EXT16 && $urandom_range(0, 2) == 0) begin
        ext = 1'b1;
        len = $urandom_range(0, lim);
      end else begin
        len = (ctrl_q > 125) ? 125 : int'(ctrl_q);
        if (len > lim) len = lim;
        if ($urandom_range(0, 3) != 0) len = $urandom_range(0, (len < 16) ? len : 16);
      end
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        len = $urandom_range(0, (lim < 16) ? lim : 16);
      end else if (pick < 18) begin
        ext = 1'b1;
        len = $urandom_range(0, (lim < 16) ? lim : 16);
      end else if (pick == 18) begin
        len = (lim < 125) ? lim : 125;
      end else begin
        ext = 1'b1;
        len = $urandom_range(126, 140);
        if (len > lim) len = lim;
      end
    end
    build_frame(op, len, ext);
    if ($urandom_range(0, 24) == 0) begin
      pick = $urandom_range(start + 1, tx_beats.size());
      while (tx_beats.size() > pick) void'(tx_beats.pop_back());
      put_beat(CMD_RESTART, rand_byte());
    end
  endfunction

  // A header with one defect, some bytes the held error makes the decoder
  // refuse, and a restart to get going again.
  function automatic void add_bad_frame();
    logic [7:0]  first;
    logic [7:0]  second;
    logic [15:0] n;
    int          kind;
    bit          ext;
    first  = HDR_TOP_BIT | {4'h0, ($urandom_range(0, 1) != 0) ? OP_TEXT : OP_BINARY};
    second = rand_byte();
    ext    = 1'b0;
    n      = 16'd0;
    kind   = $urandom_range(0, 7);
    if (kind == 7 && cap_q == 16'hFFFF) kind = 6;
    case (kind)
      0: first[6:4] = 3'($urandom_range(1, 7));
      1: first[3:0] = OP_CONTINUATION;
      2: first[3:0] = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(3, 7))
                                                   : 4'($urandom_range(11, 15));
      3: first[7] = 1'b0;
      4: second = HDR_TOP_BIT | 8'($urandom_range(0, 127));
      5: begin
        first[3:0] = ($urandom_range(0, 1) != 0) ? OP_CLOSE : OP_PING;
        second = (ctrl_q == 7'd127) ? {1'b0, LEN7_EXT64}
                                    : 8'($urandom_range(int'(ctrl_q) + 1, 127));
      end
      6: second = {1'b0, LEN7_EXT64};
      default: begin
        if (cap_q < 125 && $urandom_range(0, 1) != 0) begin
          second = 8'($urandom_range(int'(cap_q) + 1, 125));
        end else begin
          ext    = 1'b1;
          second = {1'b0, LEN7_EXT16};
          n      = 16'($urandom_range(int'(cap_q) + 1, 65535));
        end
      end
    endcase
    put_beat(CMD_DATA, first);
    put_beat(CMD_DATA, second);
    if (ext) begin
      put_beat(CMD_DATA, n[15:8]);
      put_beat(CMD_DATA, n[7:0]);
    end
    repeat ($urandom_range(0, 3)) put_beat(CMD_DATA, rand_byte());
    put_beat(CMD_RESTART, rand_byte());
  endfunction

  // Mostly well-formed frames, some broken ones, some raw noise.
  function automatic void add_random_traffic();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      add_good_frame();
    end else if (r < 92) begin
      add_bad_frame();
    end else if (r < 97) begin
      repeat ($urandom_range(1, 8)) put_beat(CMD_DATA, rand_byte());
      put_beat(CMD_RESTART, rand_byte());
    end else begin
      put_beat(CMD_RESTART, rand_byte());
    end
  endfunction

  function automatic void row(input logic cmd, input logic [7:0] data,
                              input logic fixed = 1'b0, input logic taken = 1'b0,
                              input logic [1:0] st = ST_NEED_MORE,
                              input logic [2:0] ek = ERR_NONE,
                              input logic [3:0] op = OP_CONTINUATION,
                              input logic [15:0] len = 16'd0);
    dir_row_t d;
    d                  = '0;
    d.cmd              = cmd;
    d.data             = data;
    d.fixed            = fixed;
    d.res.byte_taken   = taken;
    d.res.status       = st;
    d.res.error_kind   = ek;
    d.res.frame_opcode = op;
    d.res.frame_length = len;
    dir_table.push_back(d);
  endfunction

  // --------------------------------------------------------------------------
  // Bus functional tasks. Everything is driven at the falling edge.
  // --------------------------------------------------------------------------

  // One input beat. The sender runs in bursts with random gaps between them,
  // except while the receiver is being held off on purpose.
  task automatic send_beat(input logic cmd, input logic [7:0] data, input logic fixed,
                           input wsfd_result_t fixed_res);
    wsfd_result_t want;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
      if (hold_asked == hold_served) begin
        stream_if.valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    stream_if.valid     = 1'b1;
    stream_if.command   = cmd;
    stream_if.data_byte = data;
    do @(posedge clk); while (stream_if.ready !== 1'b1);
    want = decode_beat(cmd, data);
    due_results.push_back(fixed ? fixed_res : want);
    @(negedge clk);
  endtask

  task automatic send_queued();
    in_beat_t t;
    while (tx_beats.size() != 0) begin
      t = tx_beats.pop_front();
      send_beat(t.cmd, t.data, 1'b0, '0);
    end
  endtask

  // Registers may only change with nothing in flight; the task waits until every
  // predicted result has come back, so the registers can then be written.
  task automatic wait_idle();
    stream_if.valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == CFG_IDX_CAPACITY) cap_q = value[15:0];
    else ctrl_q = value[6:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // One stretch of random traffic under one register setting. The upper
  // bits of the written words are junk that the registers must drop.
  task automatic run_phase(input logic [15:0] cap, input logic [6:0] ctrl, input int beats,
                           input bit squeeze);
    int sent;
    wait_idle();
    write_reg(CFG_IDX_CAPACITY, {16'($urandom()), cap});
    write_reg(CFG_IDX_CTRL_LEN, {25'($urandom()), ctrl});
    if (squeeze) hold_asked++;
    sent = 0;
    while (sent < beats) begin
      add_random_traffic();
      sent += tx_beats.size();
      send_queued();
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: switches between stall patterns at random, and on request
  // refuses all beats for a stretch set by LONG_HOLD so the block backs up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int mode_left;
    int tick;
    result_if.ready = 1'b0;
    mode_left       = 0;
    tick            = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        result_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_served = hold_asked;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      tick++;
      case (mode)
        0:       result_if.ready = 1'b1;
        1:       result_if.ready = 1'($urandom_range(0, 1));
        2:       result_if.ready = (tick % 4 == 0);
        default: result_if.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every result beat must match the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    wsfd_result_t got;
    wsfd_result_t want;
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      got.byte_taken     = result_if.byte_taken;
      got.status         = result_if.status;
      got.error_kind     = result_if.error_kind;
      got.frame_opcode   = result_if.frame_opcode;
      got.frame_length   = result_if.frame_length;
      got.payload_valid  = result_if.payload_valid;
      got.payload_byte   = result_if.payload_byte;
      got.payload_offset = result_if.payload_offset;
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("%0t: result beat with no prediction pending", $realtime);
      end else begin
        want = due_results.pop_front();
        if (got.byte_taken !== want.byte_taken || got.status !== want.status ||
            got.error_kind !== want.error_kind || got.frame_opcode !== want.frame_opcode ||
            got.frame_length !== want.frame_length ||
            got.payload_valid !== want.payload_valid ||
            got.payload_byte !== want.payload_byte ||
            got.payload_offset !== want.payload_offset) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT) begin
            $display("%0t: mismatch", $realtime);
            $display("  want taken=%0d st=%0d err=%0d op=%0h len=%0d pv=%0d pb=%02h off=%0d",
                     want.byte_taken, want.status, want.error_kind, want.frame_opcode,
                     want.frame_length, want.payload_valid, want.payload_byte,
                     want.payload_offset);
            $display("  got  taken=%0d st=%0d err=%0d op=%0h len=%0d pv=%0d pb=%02h off=%0d",
                     got.byte_taken, got.status, got.error_kind, got.frame_opcode,
                     got.frame_length, got.payload_valid, got.payload_byte,
                     got.payload_offset);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main_flow
    int guard;
    fail_count          = 0;
    burst_left          = 0;
    hold_asked          = 0;
    hold_served         = 0;
    rst                 = 1'b1;
    stream_if.valid     = 1'b0;
    stream_if.command   = CMD_DATA;
    stream_if.data_byte = 8'h00;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = 3'd0;
    pwdata              = 32'd0;
    cap_q               = CAPACITY_RESET;
    ctrl_q              = CTRL_LEN_RESET;
    clear_decoder();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, run under the reset register values. Rows with a
    // typed result are the ones whose outcome is plain from the header rules;
    // each error case ends with a restart so the next case starts clean.
    row(CMD_RESTART, 8'hFF, 1'b1);                       // restart: all fields zero
    row(CMD_DATA, 8'h81);                                // FIN text
    row(CMD_DATA, 8'h00, 1'b1, 1'b1, ST_COMPLETE, ERR_NONE, OP_TEXT, 16'd0);
    row(CMD_DATA, 8'h82);                                // FIN binary, one byte
    row(CMD_DATA, 8'h01);
    row(CMD_DATA, 8'hA5);
    row(CMD_DATA, 8'h8A);                                // pong, length above limit
    row(CMD_DATA, 8'h7E, 1'b1, 1'b1, ST_ERROR, ERR_CTRL_LONG, OP_PONG);
    row(CMD_DATA, 8'h55, 1'b1, 1'b0, ST_ERROR, ERR_CTRL_LONG, OP_PONG);  // held error
    row(CMD_RESTART, 8'h00, 1'b1);
    row(CMD_DATA, 8'hF1);                                // all reserved bits set
    row(CMD_DATA, 8'h00, 1'b1, 1'b1, ST_ERROR, ERR_RESERVED);
    row(CMD_RESTART, 8'hFF, 1'b1);
    row(CMD_DATA, 8'h80);                                // continuation opcode
    row(CMD_DATA, 8'h00, 1'b1, 1'b1, ST_ERROR, ERR_FRAGMENTED);
    row(CMD_RESTART, 8'h00, 1'b1);
    row(CMD_DATA, 8'h83);                                // unknown opcode
    row(CMD_DATA, 8'h00, 1'b1, 1'b1, ST_ERROR, ERR_BAD_OPCODE);
    row(CMD_RESTART, 8'hFF, 1'b1);
    row(CMD_DATA, 8'h01);                                // FIN clear
    row(CMD_DATA, 8'h00, 1'b1, 1'b1, ST_ERROR, ERR_FRAGMENTED);
    row(CMD_RESTART, 8'h00, 1'b1);
    row(CMD_DATA, 8'h82);                                // mask bit wins over length 127
    row(CMD_DATA, 8'hFF, 1'b1, 1'b1, ST_ERROR, ERR_MASKED);
    row(CMD_RESTART, 8'hFF, 1'b1);
    row(CMD_DATA, 8'h82);                                // 64-bit length marker
    row(CMD_DATA, 8'h7F, 1'b1, 1'b1, ST_ERROR, ERR_TOO_LARGE, OP_BINARY);
    row(CMD_RESTART, 8'h00, 1'b1);
    foreach (dir_table[i])
      send_beat(dir_table[i].cmd, dir_table[i].data, dir_table[i].fixed, dir_table[i].res);

    // Random traffic across register settings, extremes included. The first
    // and third phases start with the receiver held off.
    run_phase(16'hFFFF, 7'd125, 150, 1'b1);
    run_phase(16'd0,    7'd0,   100, 1'b0);
    run_phase(16'hFFFF, 7'd127, 140, 1'b1);
    run_phase(16'd200,  7'd126, 140, 1'b0);
    run_phase(16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)), 140, 1'b0);

    // Boundary frames: a frame exactly at the buffer capacity, then the
    // 7-bit and extended length boundaries.
    wait_idle();
    write_reg(CFG_IDX_CAPACITY, {16'h0000, 16'd140});
    write_reg(CFG_IDX_CTRL_LEN, {25'd0, CTRL_LEN_RESET});
    build_frame(OP_BINARY, 140, 1'b1);
    build_frame(OP_PING, 125, 1'b0);
    build_frame(OP_TEXT, 126, 1'b1);
    send_queued();

    // Drain, then give the pipeline a few more cycles to show stray beats.
    stream_if.valid = 1'b0;
    guard = 0;
    while (due_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      fail_count++;
      $display("%0d predicted results never arrived", due_results.size());
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
